FILE: hw/rtl/lscf_pkg.sv
// Shared types, constants and the solver microcode for the circle fit block.
package lscf_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int COORD_BITS = 11;
  localparam int MIN_POINTS = 3;
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int LOG_N = $clog2(MAX_POINTS);
  localparam int S1_W = COORD_BITS + LOG_N;
  localparam int S2_W = 2 * COORD_BITS + LOG_N;
  localparam int S3_W = 3 * COORD_BITS + LOG_N + 1;
  localparam int SQ_W = 2 * COORD_BITS;
  localparam int CU_W = 3 * COORD_BITS;
  localparam int WIDE_W = 9 * CNT_W + 10 * COORD_BITS + 16;
  localparam int CYC_W = $clog2(WIDE_W);
  localparam int CEN_W = 16;
  localparam int RAD_BITS = 20;
  localparam int SLOT_W = 5;
  localparam int RF_DEPTH = 32;
  localparam int PC_W = 6;

  localparam logic [CEN_W:0] CEN_POS = (CEN_W + 1)'((1 << (CEN_W - 1)) - 1);
  localparam logic [CEN_W:0] CEN_NEG = (CEN_W + 1)'(1 << (CEN_W - 1));

  typedef logic [WIDE_W-1:0] wide_t;
  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic [1:0] {
    FIT_OK    = 2'd0,
    FIT_FEW   = 2'd1,
    FIT_DEGEN = 2'd2
  } fit_status_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] point_x;
    logic [COORD_BITS-1:0] point_y;
    logic                  last_point;
  } point_t;

  typedef struct packed {
    logic signed [CEN_W-1:0] center_x;
    logic signed [CEN_W-1:0] center_y;
    logic [RAD_BITS-1:0]     fit_radius;
    fit_status_t             fit_status;
  } result_t;

  typedef enum logic [3:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_CENX,
    OP_CENY,
    OP_DIVR,
    OP_SQRT,
    OP_CHK,
    OP_END
  } op_t;

  typedef struct packed {
    op_t   op;
    slot_t dst;
    slot_t a;
    slot_t b;
  } instr_t;

  typedef enum logic [2:0] {
    TS_IDLE,
    TS_PROD,
    TS_LOAD,
    TS_FETCH,
    TS_EXEC,
    TS_WAIT,
    TS_DONE
  } top_state_t;

  typedef enum logic [2:0] {
    AS_IDLE,
    AS_MUL,
    AS_DIV,
    AS_SQRT,
    AS_DONE
  } alu_state_t;

  localparam slot_t SL_N    = 5'd0;
  localparam slot_t SL_SX   = 5'd1;
  localparam slot_t SL_SY   = 5'd2;
  localparam slot_t SL_SXX  = 5'd3;
  localparam slot_t SL_SYY  = 5'd4;
  localparam slot_t SL_SXY  = 5'd5;
  localparam slot_t SL_SXXX = 5'd6;
  localparam slot_t SL_SYYY = 5'd7;
  localparam slot_t SL_SXYY = 5'd8;
  localparam slot_t SL_SXXY = 5'd9;
  localparam slot_t SL_S2   = 5'd10;
  localparam slot_t SL_C    = 5'd11;
  localparam slot_t SL_D    = 5'd12;
  localparam slot_t SL_G    = 5'd13;
  localparam slot_t SL_E    = 5'd14;
  localparam slot_t SL_H    = 5'd15;
  localparam slot_t SL_DET  = 5'd16;
  localparam slot_t SL_PX   = 5'd17;
  localparam slot_t SL_PY   = 5'd18;
  localparam slot_t SL_Q    = 5'd19;
  localparam slot_t SL_T1   = 5'd20;
  localparam slot_t SL_T2   = 5'd21;
  localparam slot_t SL_T3   = 5'd22;
  localparam slot_t SL_T4   = 5'd23;
  localparam slot_t SL_T5   = 5'd24;
  localparam slot_t SL_DEN  = 5'd25;
  localparam slot_t SL_R2   = 5'd26;

  function automatic instr_t ucode(pc_t pc);
    instr_t ins;
    case (pc)
      6'd0: ins = '{OP_ADD, SL_S2, SL_SXX, SL_SYY};
      6'd1: ins = '{OP_MUL, SL_T1, SL_N, SL_SXX};
      6'd2: ins = '{OP_MUL, SL_T2, SL_SX, SL_SX};
      6'd3: ins = '{OP_SUB, SL_C, SL_T1, SL_T2};
      6'd4: ins = '{OP_MUL, SL_T1, SL_N, SL_SXY};
      6'd5: ins = '{OP_MUL, SL_T2, SL_SX, SL_SY};
      6'd6: ins = '{OP_SUB, SL_D, SL_T1, SL_T2};
      6'd7: ins = '{OP_MUL, SL_T1, SL_N, SL_SYY};
      6'd8: ins = '{OP_MUL, SL_T2, SL_SY, SL_SY};
      6'd9: ins = '{OP_SUB, SL_G, SL_T1, SL_T2};
      6'd10: ins = '{OP_ADD, SL_T3, SL_SXXX, SL_SXYY};
      6'd11: ins = '{OP_MUL, SL_T1, SL_N, SL_T3};
      6'd12: ins = '{OP_MUL, SL_T2, SL_S2, SL_SX};
      6'd13: ins = '{OP_SUB, SL_E, SL_T1, SL_T2};
      6'd14: ins = '{OP_ADD, SL_T3, SL_SXXY, SL_SYYY};
      6'd15: ins = '{OP_MUL, SL_T1, SL_N, SL_T3};
      6'd16: ins = '{OP_MUL, SL_T2, SL_S2, SL_SY};
      6'd17: ins = '{OP_SUB, SL_H, SL_T1, SL_T2};
      6'd18: ins = '{OP_MUL, SL_T1, SL_C, SL_G};
      6'd19: ins = '{OP_MUL, SL_T2, SL_D, SL_D};
      6'd20: ins = '{OP_SUB, SL_DET, SL_T1, SL_T2};
      6'd21: ins = '{OP_CHK, SL_DET, SL_DET, SL_DET};
      6'd22: ins = '{OP_MUL, SL_T1, SL_E, SL_G};
      6'd23: ins = '{OP_MUL, SL_T2, SL_H, SL_D};
      6'd24: ins = '{OP_SUB, SL_PX, SL_T1, SL_T2};
      6'd25: ins = '{OP_MUL, SL_T1, SL_H, SL_C};
      6'd26: ins = '{OP_MUL, SL_T2, SL_E, SL_D};
      6'd27: ins = '{OP_SUB, SL_PY, SL_T1, SL_T2};
      6'd28: ins = '{OP_ADD, SL_Q, SL_DET, SL_DET};
      6'd29: ins = '{OP_CENX, SL_T1, SL_PX, SL_Q};
      6'd30: ins = '{OP_CENY, SL_T1, SL_PY, SL_Q};
      6'd31: ins = '{OP_MUL, SL_T1, SL_PX, SL_PX};
      6'd32: ins = '{OP_MUL, SL_T2, SL_PY, SL_PY};
      6'd33: ins = '{OP_ADD, SL_T1, SL_T1, SL_T2};
      6'd34: ins = '{OP_MUL, SL_T1, SL_N, SL_T1};
      6'd35: ins = '{OP_MUL, SL_T2, SL_Q, SL_Q};
      6'd36: ins = '{OP_MUL, SL_T3, SL_S2, SL_T2};
      6'd37: ins = '{OP_ADD, SL_T1, SL_T1, SL_T3};
      6'd38: ins = '{OP_MUL, SL_T4, SL_PX, SL_SX};
      6'd39: ins = '{OP_MUL, SL_T5, SL_PY, SL_SY};
      6'd40: ins = '{OP_ADD, SL_T4, SL_T4, SL_T5};
      6'd41: ins = '{OP_MUL, SL_T4, SL_Q, SL_T4};
      6'd42: ins = '{OP_ADD, SL_T4, SL_T4, SL_T4};
      6'd43: ins = '{OP_SUB, SL_T1, SL_T1, SL_T4};
      6'd44, 6'd45, 6'd46, 6'd47, 6'd48, 6'd49, 6'd50, 6'd51:
        ins = '{OP_ADD, SL_T1, SL_T1, SL_T1};
      6'd52: ins = '{OP_MUL, SL_DEN, SL_N, SL_T2};
      6'd53: ins = '{OP_DIVR, SL_R2, SL_T1, SL_DEN};
      6'd54: ins = '{OP_SQRT, SL_R2, SL_R2, SL_R2};
      default: ins = '{OP_END, SL_N, SL_N, SL_N};
    endcase
    return ins;
  endfunction

endpackage

FILE: hw/rtl/least_squares_circle_fit_top.sv
// Top level of the algebraic least-squares circle fit.
// One point is transferred when start is high while busy is low. Each point then
// takes eight steps of a small 11 by 22 bit multiplier that updates the power
// sums. The point marked last then starts the solve, which copies the sums into
// a 32-entry register file and runs a fixed microprogram on one bit-serial
// arithmetic unit of WIDE_W (225) bits: 25 multiplications, three divisions, a
// 20-step square root and additions and subtractions, during which busy stays
// high. A set of fewer than three points skips the solve. The result is shown
// for exactly one cycle with done high; the receiver cannot stall it.
module least_squares_circle_fit_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  lscf_pkg::point_t  point,
  output logic              busy,
  output logic              done,
  output lscf_pkg::result_t result
);
  import lscf_pkg::*;

  localparam logic [3:0] PROD_LAST = 4'd7;
  localparam logic [3:0] LOAD_LAST = 4'd9;

  top_state_t state, state_next;
  logic [3:0] step;
  pc_t pc;
  instr_t ins;
  point_t pt;
  logic [CNT_W-1:0] count;
  logic [S1_W-1:0] acc_x, acc_y;
  logic [S2_W-1:0] acc_xx, acc_yy, acc_xy;
  logic [S3_W-1:0] acc_xxx, acc_yyy, acc_xyy, acc_xxy;
  logic [SQ_W-1:0] sq_x, sq_y;
  logic [CU_W-1:0] prod;
  logic [COORD_BITS-1:0] mul_a;
  logic [SQ_W-1:0] mul_b;
  logic signed [CEN_W-1:0] cx, cy;
  logic [RAD_BITS-1:0] rad;
  fit_status_t status;

  logic ram_we;
  slot_t ram_waddr;
  wide_t ram_wdata, load_data, rd_a, rd_b, alu_res;
  logic alu_start, alu_done, det_bad, few, room;

  assign ins = ucode(pc);
  assign few = (count < CNT_W'(MIN_POINTS));
  assign room = (count < CNT_W'(MAX_POINTS));
  assign det_bad = (~|rd_a) || rd_a[WIDE_W-1];

  lscf_ram #(
    .WIDTH(WIDE_W),
    .DEPTH(RF_DEPTH)
  ) u_rf (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (ram_waddr),
    .wdata  (ram_wdata),
    .raddr_a(ins.a),
    .raddr_b(ins.b),
    .rdata_a(rd_a),
    .rdata_b(rd_b)
  );

  lscf_alu u_alu (
    .clk  (clk),
    .rst  (rst),
    .start(alu_start),
    .op   (ins.op),
    .a    (rd_a),
    .b    (rd_b),
    .done (alu_done),
    .res  (alu_res)
  );

  always_comb begin
    case (step)
      4'd0: load_data = WIDE_W'(count);
      4'd1: load_data = WIDE_W'(acc_x);
      4'd2: load_data = WIDE_W'(acc_y);
      4'd3: load_data = WIDE_W'(acc_xx);
      4'd4: load_data = WIDE_W'(acc_yy);
      4'd5: load_data = WIDE_W'(acc_xy);
      4'd6: load_data = WIDE_W'(acc_xxx);
      4'd7: load_data = WIDE_W'(acc_yyy);
      4'd8: load_data = WIDE_W'(acc_xyy);
      default: load_data = WIDE_W'(acc_xxy);
    endcase
  end

  always_comb begin
    case (step)
      4'd0: begin
        mul_a = pt.point_x;
        mul_b = SQ_W'(pt.point_x);
      end
      4'd1: begin
        mul_a = pt.point_y;
        mul_b = SQ_W'(pt.point_y);
      end
      4'd2: begin
        mul_a = pt.point_x;
        mul_b = SQ_W'(pt.point_y);
      end
      4'd3: begin
        mul_a = pt.point_x;
        mul_b = sq_x;
      end
      4'd4: begin
        mul_a = pt.point_y;
        mul_b = sq_y;
      end
      4'd5: begin
        mul_a = pt.point_x;
        mul_b = sq_y;
      end
      default: begin
        mul_a = pt.point_y;
        mul_b = sq_x;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      TS_IDLE: begin
        if (start) begin
          if (room) begin
            state_next = TS_PROD;
          end else if (point.last_point) begin
            state_next = TS_LOAD;
          end
        end
      end
      TS_PROD: begin
        if (step == PROD_LAST) begin
          state_next = pt.last_point ? TS_LOAD : TS_IDLE;
        end
      end
      TS_LOAD: begin
        if (few) begin
          state_next = TS_DONE;
        end else if (step == LOAD_LAST) begin
          state_next = TS_FETCH;
        end
      end
      TS_FETCH: state_next = TS_EXEC;
      TS_EXEC: begin
        case (ins.op)
          OP_CHK: state_next = det_bad ? TS_DONE : TS_FETCH;
          OP_END: state_next = TS_DONE;
          default: state_next = TS_WAIT;
        endcase
      end
      TS_WAIT: begin
        if (alu_done) begin
          state_next = TS_FETCH;
        end
      end
      TS_DONE: state_next = TS_IDLE;
      default: state_next = TS_IDLE;
    endcase
  end

  always_comb begin
    busy = (state != TS_IDLE);
    done = (state == TS_DONE);
    alu_start = 1'b0;
    ram_we = 1'b0;
    ram_waddr = ins.dst;
    ram_wdata = alu_res;
    case (state)
      TS_LOAD: begin
        ram_we = 1'b1;
        ram_waddr = SLOT_W'(step);
        ram_wdata = load_data;
      end
      TS_EXEC: begin
        alu_start = (ins.op != OP_CHK) && (ins.op != OP_END);
      end
      TS_WAIT: begin
        ram_we = alu_done && ((ins.op == OP_ADD) || (ins.op == OP_SUB) ||
                              (ins.op == OP_MUL) || (ins.op == OP_DIVR));
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= TS_IDLE;
      step <= '0;
      pc <= '0;
      count <= '0;
      acc_x <= '0;
      acc_y <= '0;
      acc_xx <= '0;
      acc_yy <= '0;
      acc_xy <= '0;
      acc_xxx <= '0;
      acc_yyy <= '0;
      acc_xyy <= '0;
      acc_xxy <= '0;
    end else begin
      state <= state_next;
      step <= (state_next != state) ? 4'd0 : step + 1'b1;
      case (state)
        TS_PROD: begin
          case (step)
            4'd1: acc_xx <= acc_xx + S2_W'(prod);
            4'd2: acc_yy <= acc_yy + S2_W'(prod);
            4'd3: acc_xy <= acc_xy + S2_W'(prod);
            4'd4: acc_xxx <= acc_xxx + S3_W'(prod);
            4'd5: acc_yyy <= acc_yyy + S3_W'(prod);
            4'd6: acc_xyy <= acc_xyy + S3_W'(prod);
            4'd7: begin
              acc_xxy <= acc_xxy + S3_W'(prod);
              acc_x <= acc_x + S1_W'(pt.point_x);
              acc_y <= acc_y + S1_W'(pt.point_y);
              count <= count + 1'b1;
            end
            default: acc_x <= acc_x;
          endcase
        end
        TS_LOAD: pc <= '0;
        TS_EXEC: begin
          if (ins.op == OP_CHK) begin
            pc <= pc + 1'b1;
          end
        end
        TS_WAIT: begin
          if (alu_done) begin
            pc <= pc + 1'b1;
          end
        end
        TS_DONE: begin
          count <= '0;
          acc_x <= '0;
          acc_y <= '0;
          acc_xx <= '0;
          acc_yy <= '0;
          acc_xy <= '0;
          acc_xxx <= '0;
          acc_yyy <= '0;
          acc_xyy <= '0;
          acc_xxy <= '0;
        end
        default: pc <= pc;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == TS_IDLE && start) begin
      pt <= point;
    end
    prod <= CU_W'(mul_a * mul_b);
    if (state == TS_PROD && step == 4'd1) begin
      sq_x <= prod[SQ_W-1:0];
    end
    if (state == TS_PROD && step == 4'd2) begin
      sq_y <= prod[SQ_W-1:0];
    end
    if (state == TS_LOAD && step == 4'd0) begin
      cx <= '0;
      cy <= '0;
      rad <= '0;
      status <= few ? FIT_FEW : FIT_OK;
    end
    if (state == TS_EXEC && ins.op == OP_CHK && det_bad) begin
      status <= FIT_DEGEN;
    end
    if (state == TS_WAIT && alu_done) begin
      case (ins.op)
        OP_CENX: cx <= alu_res[CEN_W-1:0];
        OP_CENY: cy <= alu_res[CEN_W-1:0];
        OP_SQRT: rad <= alu_res[RAD_BITS-1:0];
        default: rad <= rad;
      endcase
    end
  end

  assign result.center_x = cx;
  assign result.center_y = cy;
  assign result.fit_radius = rad;
  assign result.fit_status = status;

endmodule

FILE: hw/rtl/lscf_ram.sv
// Generic RAM with one write port and two registered read ports.
module lscf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

FILE: hw/rtl/lscf_alu.sv
// Shared bit-serial arithmetic unit: add, subtract, multiply, divide and square root.
module lscf_alu (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  lscf_pkg::op_t op,
  input  lscf_pkg::wide_t a,
  input  lscf_pkg::wide_t b,
  output logic          done,
  output lscf_pkg::wide_t res
);
  import lscf_pkg::*;

  alu_state_t st, st_next;
  op_t opr;
  wide_t ra, rb, rr;
  logic neg;
  logic [CYC_W-1:0] cnt;

  wide_t add_x, add_y;
  logic add_sub;
  logic [WIDE_W:0] add_s;
  logic ge;
  wide_t rem2;
  logic [RAD_BITS+2:0] sq_rem2;
  logic [RAD_BITS+1:0] trial;
  wide_t sq_in;
  logic big;
  logic [CEN_W:0] lim, mag, sval;

  assign rem2 = {rr[WIDE_W-2:0], ra[WIDE_W-1]};
  assign sq_rem2 = {rr[RAD_BITS:0], ra[2*RAD_BITS-1:2*RAD_BITS-2]};
  assign trial = {rb[RAD_BITS-1:0], 2'b01};
  assign sq_in = (|a[WIDE_W-1:2*RAD_BITS]) ? WIDE_W'({(2 * RAD_BITS){1'b1}}) :
                 WIDE_W'(a[2*RAD_BITS-1:0]);

  always_comb begin
    add_x = '0;
    add_y = '0;
    add_sub = 1'b0;
    case (st)
      AS_IDLE: begin
        case (op)
          OP_SUB: begin
            add_x = a;
            add_y = b;
            add_sub = 1'b1;
          end
          OP_CENX, OP_CENY: begin
            add_y = a;
            add_sub = 1'b1;
          end
          default: begin
            add_x = a;
            add_y = b;
          end
        endcase
      end
      AS_MUL: begin
        add_x = rr;
        add_y = rb[0] ? ra : '0;
      end
      AS_DIV: begin
        add_x = rem2;
        add_y = rb;
        add_sub = 1'b1;
      end
      AS_SQRT: begin
        add_x = WIDE_W'(sq_rem2);
        add_y = WIDE_W'(trial);
        add_sub = 1'b1;
      end
      default: begin
        add_x = '0;
      end
    endcase
  end

  assign add_s = {1'b0, add_x} + ({1'b0, add_y} ^ {(WIDE_W + 1){add_sub}}) +
                 (WIDE_W + 1)'(add_sub);
  assign ge = !add_s[WIDE_W];

  always_comb begin
    st_next = st;
    case (st)
      AS_IDLE: begin
        if (start) begin
          case (op)
            OP_MUL: st_next = AS_MUL;
            OP_CENX, OP_CENY: st_next = AS_DIV;
            OP_DIVR: st_next = a[WIDE_W-1] ? AS_DONE : AS_DIV;
            OP_SQRT: st_next = AS_SQRT;
            default: st_next = AS_DONE;
          endcase
        end
      end
      AS_MUL, AS_DIV: begin
        if (cnt == CYC_W'(WIDE_W - 1)) begin
          st_next = AS_DONE;
        end
      end
      AS_SQRT: begin
        if (cnt == CYC_W'(RAD_BITS - 1)) begin
          st_next = AS_DONE;
        end
      end
      AS_DONE: st_next = AS_IDLE;
      default: st_next = AS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= AS_IDLE;
    end else begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    case (st)
      AS_IDLE: begin
        if (start) begin
          opr <= op;
          cnt <= '0;
          neg <= a[WIDE_W-1];
          case (op)
            OP_ADD, OP_SUB: begin
              rr <= add_s[WIDE_W-1:0];
              rb <= b;
            end
            OP_CENX, OP_CENY: begin
              ra <= a[WIDE_W-1] ? add_s[WIDE_W-1:0] : a;
              rr <= '0;
              rb <= b;
            end
            OP_DIVR: begin
              ra <= a[WIDE_W-1] ? '0 : a;
              rr <= '0;
              rb <= b;
            end
            OP_SQRT: begin
              ra <= sq_in;
              rr <= '0;
              rb <= '0;
            end
            default: begin
              ra <= a;
              rr <= '0;
              rb <= b;
            end
          endcase
        end
      end
      AS_MUL: begin
        rr <= add_s[WIDE_W-1:0];
        ra <= {ra[WIDE_W-2:0], 1'b0};
        rb <= {1'b0, rb[WIDE_W-1:1]};
        cnt <= cnt + 1'b1;
      end
      AS_DIV: begin
        rr <= ge ? add_s[WIDE_W-1:0] : rem2;
        ra <= {ra[WIDE_W-2:0], ge};
        cnt <= cnt + 1'b1;
      end
      AS_SQRT: begin
        rr <= ge ? add_s[WIDE_W-1:0] : WIDE_W'(sq_rem2);
        rb <= {rb[WIDE_W-2:0], ge};
        ra <= {ra[WIDE_W-3:0], 2'b00};
        cnt <= cnt + 1'b1;
      end
      default: begin
        cnt <= cnt;
      end
    endcase
  end

  assign lim = neg ? CEN_NEG : CEN_POS;
  assign big = (|ra[WIDE_W-1:CEN_W+1]) || (ra[CEN_W:0] > lim);
  assign mag = big ? lim : ra[CEN_W:0];
  assign sval = neg ? ((CEN_W + 1)'(0) - mag) : mag;

  always_comb begin
    done = (st == AS_DONE);
    case (opr)
      OP_DIVR: res = ra;
      OP_SQRT: res = rb;
      OP_CENX, OP_CENY: res = {{(WIDE_W - CEN_W){sval[CEN_W-1]}}, sval[CEN_W-1:0]};
      default: res = rr;
    endcase
  end

endmodule

FILE: hw/rtl/lscf_checker.sv
// Port-level assertions for the circle fit top level, with the bind that attaches them.
module lscf_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input lscf_pkg::point_t  point,
  input logic              busy,
  input logic              done,
  input lscf_pkg::result_t result
);
  import lscf_pkg::*;

  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("Result shown while not busy.");

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |=> !busy)
    else $error("Block still busy after a result transfer.");

  a_no_fast_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !done)
    else $error("Result in the cycle after a point transfer.");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.fit_status != FIT_OK) |->
    (result.center_x == '0 && result.center_y == '0 && result.fit_radius == '0))
    else $error("Failed fit with non-zero fields.");

  a_point_dropped: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && point.last_point) |=> busy)
    else $error("Last point did not start a fit.");

endmodule

bind least_squares_circle_fit_top lscf_checker u_lscf_checker (.*);

FILE: sim/least_squares_circle_fit_top_test.sv
// Self-checking testbench for the circle fit: fixed and random sets against an exact model.
`timescale 1ns / 1ps
module least_squares_circle_fit_top_test;
  import lscf_pkg::*;

  typedef logic signed [383:0] big_t;

  logic    clk;
  logic    rst;
  logic    start;
  point_t  point;
  logic    busy;
  logic    done;
  result_t result;

  point_t  point_q[$];
  result_t fit_q[$];
  int      idle_pct;
  int      error_cnt = 0;
  int      fit_cnt = 0;
  int      point_cnt = 0;

  longint unsigned n_pts = 0, s_x = 0, s_y = 0, s_xx = 0, s_yy = 0, s_xy = 0;
  longint unsigned s_xxx = 0, s_yyy = 0, s_xyy = 0, s_xxy = 0;

  least_squares_circle_fit_top i_dut (
    .clk(clk), .rst(rst), .start(start), .point(point),
    .busy(busy), .done(done), .result(result)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic logic [15:0] centre_of(big_t p, big_t q);
    big_t t;
    t = p / q;
    if (t > 32767) return 16'sh7fff;
    if (t < -32768) return 16'sh8000;
    return t[15:0];
  endfunction

  function automatic result_t solve_fit();
    result_t r;
    big_t n, sx, sy, s2, c, d, g, e, h, det, px, py, q, num, den, r2;
    longint unsigned v, root, trial;
    r = '0;
    if (n_pts < MIN_POINTS) begin
      r.fit_status = FIT_FEW;
      return r;
    end
    n = big_t'(n_pts);
    sx = big_t'(s_x);
    sy = big_t'(s_y);
    s2 = big_t'(s_xx) + big_t'(s_yy);
    c = n * big_t'(s_xx) - sx * sx;
    d = n * big_t'(s_xy) - sx * sy;
    g = n * big_t'(s_yy) - sy * sy;
    e = n * (big_t'(s_xxx) + big_t'(s_xyy)) - s2 * sx;
    h = n * (big_t'(s_xxy) + big_t'(s_yyy)) - s2 * sy;
    det = c * g - d * d;
    if (det <= 0) begin
      r.fit_status = FIT_DEGEN;
      return r;
    end
    px = e * g - h * d;
    py = h * c - e * d;
    q = det + det;
    r.center_x = centre_of(px, q);
    r.center_y = centre_of(py, q);
    num = n * (px * px + py * py) + s2 * q * q - 2 * q * (px * sx + py * sy);
    num = num * 256;
    den = n * q * q;
    root = 0;
    if (num >= 0) begin
      r2 = num / den;
      if (r2 >= (big_t'(1) <<< 40)) begin
        root = 64'hfffff;
      end else begin
        v = r2[63:0];
        for (int b = 19; b >= 0; b--) begin
          trial = root | (64'd1 << b);
          if (trial * trial <= v) root = trial;
        end
      end
    end
    r.fit_radius = root[19:0];
    r.fit_status = FIT_OK;
    return r;
  endfunction

  task automatic take_point(point_t p);
    longint unsigned x, y;
    x = p.point_x;
    y = p.point_y;
    point_cnt++;
    if (n_pts < MAX_POINTS) begin
      s_x += x; s_y += y;
      s_xx += x * x; s_yy += y * y; s_xy += x * y;
      s_xxx += x * x * x; s_yyy += y * y * y;
      s_xyy += x * y * y; s_xxy += x * x * y;
      n_pts++;
    end
    if (p.last_point) begin
      fit_q.push_back(solve_fit());
      {n_pts, s_x, s_y, s_xx, s_yy, s_xy, s_xxx, s_yyy, s_xyy, s_xxy} = '0;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      point <= '0;
    end else begin
      if (start && !busy) begin
        take_point(point);
        void'(point_q.pop_front());
      end
      if (point_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
        start <= 1'b1;
        point <= point_q[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      if (fit_q.size() == 0) begin
        $display("%0t: unexpected result %p", $realtime, result);
        error_cnt++;
      end else begin
        result_t want;
        want = fit_q.pop_front();
        fit_cnt++;
        if (result.center_x !== want.center_x)
          $display("%0t: center_x expected %0d, got %0d", $realtime, want.center_x,
                   result.center_x);
        if (result.center_y !== want.center_y)
          $display("%0t: center_y expected %0d, got %0d", $realtime, want.center_y,
                   result.center_y);
        if (result.fit_radius !== want.fit_radius)
          $display("%0t: fit_radius expected %0d, got %0d", $realtime, want.fit_radius,
                   result.fit_radius);
        if (result.fit_status !== want.fit_status)
          $display("%0t: fit_status expected %0d, got %0d", $realtime, want.fit_status,
                   result.fit_status);
        if (result !== want) error_cnt++;
      end
    end
  end

  function automatic void push_point(int x, int y, bit last);
    point_t p;
    if (x < 0) x = 0;
    if (x > 2047) x = 2047;
    if (y < 0) y = 0;
    if (y > 2047) y = 2047;
    p.point_x = x[10:0];
    p.point_y = y[10:0];
    p.last_point = last;
    point_q.push_back(p);
  endfunction

  // Adds one point set of a randomly chosen kind and returns its size.
  function automatic int add_random_set();
    int kind, size, cx, cy, rad, x0, y0, dx, dy;
    real ang;
    kind = $urandom_range(99);
    size = $urandom_range(3, 10);
    if (kind < 70) begin
      cx = $urandom_range(2047);
      cy = $urandom_range(2047);
      rad = ($urandom_range(3) == 0) ? $urandom_range(1, 1500) : $urandom_range(2, 200);
      for (int i = 0; i < size; i++) begin
        ang = 6.2831853 * $urandom_range(999) / 1000.0;
        push_point(cx + $rtoi(rad * $cos(ang)) + $urandom_range(2) - 1,
                   cy + $rtoi(rad * $sin(ang)) + $urandom_range(2) - 1, i == size - 1);
      end
    end else if (kind < 80) begin
      size = $urandom_range(1, 2);
      for (int i = 0; i < size; i++)
        push_point($urandom_range(2047), $urandom_range(2047), i == size - 1);
    end else if (kind < 88) begin
      x0 = $urandom_range(2047);
      y0 = $urandom_range(2047);
      dx = $urandom_range(4) - 2;
      dy = $urandom_range(4) - 2;
      for (int i = 0; i < size; i++)
        push_point(x0 + i * dx, y0 + i * dy, i == size - 1);
    end else begin
      for (int i = 0; i < size; i++)
        push_point($urandom_range(2047), $urandom_range(2047), i == size - 1);
    end
    return size;
  endfunction

  task automatic run_phase(int pct, int items);
    int added;
    idle_pct = pct;
    added = 0;
    while (added < items) added += add_random_set();
    wait (point_q.size() == 0 && !start);
    wait (fit_q.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    idle_pct = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    push_point(5, 9, 1);
    push_point(0, 0, 0);
    push_point(2047, 2047, 1);
    push_point(100, 100, 0);
    push_point(100, 100, 0);
    push_point(100, 100, 1);
    push_point(0, 0, 0);
    push_point(1024, 1024, 0);
    push_point(2047, 2047, 1);
    push_point(0, 0, 0);
    push_point(2047, 0, 0);
    push_point(0, 2047, 1);
    push_point(2047, 2047, 0);
    push_point(0, 2047, 0);
    push_point(2047, 0, 0);
    push_point(0, 0, 1);
    push_point(0, 0, 0);
    push_point(1024, 1, 0);
    push_point(2047, 0, 1);
    push_point(0, 2047, 0);
    push_point(1, 0, 0);
    push_point(2047, 1, 1);
    push_point(10, 20, 0);
    push_point(30, 40, 0);
    push_point(11, 60, 1);
    wait (point_q.size() == 0 && !start);
    wait (fit_q.size() == 0);
    repeat (20) @(posedge clk);

    // Overlong set: the points past the limit must be ignored.
    for (int i = 0; i < MAX_POINTS + 6; i++)
      push_point(i[0] ? 2047 : $urandom_range(2047), i[1] ? 2047 : $urandom_range(2047),
                 i == MAX_POINTS + 5);
    run_phase(0, 150);
    run_phase(50, 150);
    run_phase(0, 150);
    run_phase(30, 150);

    repeat (50) @(posedge clk);
    $display("Covered %0d points and %0d fits, including too-few, collinear,", point_cnt,
             fit_cnt);
    $display("saturating and overlong sets, with and without sender gaps.");
    if (error_cnt == 0 && fit_q.size() == 0) begin
      $display("least_squares_circle_fit_top_test: clean");
    end else begin
      $display("least_squares_circle_fit_top_test: errors");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("least_squares_circle_fit_top_test: errors");
    $finish;
  end

endmodule
